// ----- sv/block_buffer_lru_manager_assert.svh -----
// ----------------------------------------------------------------------------
// Block buffer LRU manager: assertion macros
// Shared property shorthands for the modules of the buffer manager. Both
// macros sample on clk and are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BLOCK_BUFFER_LRU_MANAGER_ASSERT_SVH
`define BLOCK_BUFFER_LRU_MANAGER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBL_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("bbl: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BBL_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("bbl: next-cycle check failed");

`endif

// ----- sv/bbl_pkg.sv -----
// ----------------------------------------------------------------------------
// Block buffer LRU manager: package
// Field widths, command codes, state encodings and the structs that pass
// between the manager and its LRU unit.
// ----------------------------------------------------------------------------
package bbl_pkg;

  localparam int NUM_BUFFERS_DEF = 8;
  localparam int KIND_W          = 3;
  localparam int BLOCK_W         = 32;
  localparam int INDEX_W         = 3;

  // All ones is the reserved block number and marks an unassigned buffer.
  localparam logic [BLOCK_W-1:0] BLOCK_NONE = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_GET    = 3'd0,
    KIND_UPDATE = 3'd1,
    KIND_SAVE   = 3'd2,
    KIND_FLUSH  = 3'd3,
    KIND_EMPTY  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TSCAN,
    S_VICT,
    S_OLDTAG,
    S_MTF,
    S_SAVE,
    S_RESP
  } mgr_state_t;

  typedef enum logic [1:0] {
    W_IDLE,
    W_MOVE,
    W_VICT
  } walk_state_t;

  // Requests from the manager to the LRU unit.
  typedef struct packed {
    logic mtf_go;
    logic vict_go;
    logic clear;
  } lru_ctl_t;

  // Status from the LRU unit back to the manager.
  typedef struct packed {
    logic mtf_done;
    logic vict_valid;
  } lru_sts_t;

  // One result beat.
  typedef struct packed {
    logic [INDEX_W-1:0] buffer_index;
    logic               writeback_valid;
    logic [BLOCK_W-1:0] writeback_block;
    logic               fill_valid;
    logic [BLOCK_W-1:0] fill_block;
    logic               hit;
    logic               error;
    logic               last;
  } result_t;

endpackage

// ----- sv/bbl_in_if.sv -----
// ----------------------------------------------------------------------------
// Block buffer LRU manager: command channel
// Valid/ready channel that carries one command beat.
// ----------------------------------------------------------------------------
interface bbl_in_if;
  import bbl_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [BLOCK_W-1:0] block_number;
  logic               read_contents;

  modport source (output valid, kind, block_number, read_contents, input ready);
  modport sink   (input valid, kind, block_number, read_contents, output ready);

endinterface

// ----- sv/bbl_out_if.sv -----
// ----------------------------------------------------------------------------
// Block buffer LRU manager: result channel
// Valid/ready channel that carries one result beat.
// ----------------------------------------------------------------------------
interface bbl_out_if;
  import bbl_pkg::*;

  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] buffer_index;
  logic               writeback_valid;
  logic [BLOCK_W-1:0] writeback_block;
  logic               fill_valid;
  logic [BLOCK_W-1:0] fill_block;
  logic               hit;
  logic               error;
  logic               last;

  modport source (
    output valid, buffer_index, writeback_valid, writeback_block,
           fill_valid, fill_block, hit, error, last,
    input  ready
  );
  modport sink (
    input  valid, buffer_index, writeback_valid, writeback_block,
           fill_valid, fill_block, hit, error, last,
    output ready
  );

endinterface

// ----- sv/bbl_ram.sv -----
// ----------------------------------------------------------------------------
// Block buffer LRU manager: generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bbl_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 8,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/bbl_lru_unit.sv -----
// ----------------------------------------------------------------------------
// Block buffer LRU manager: recency order unit
// Holds the most-recent-first buffer order in a RAM. A move-to-front walks
// the order from the head, one position a cycle, shifting each entry down
// until the target is found. A victim request reads the tail position.
// ----------------------------------------------------------------------------
`include "block_buffer_lru_manager_assert.svh"

module bbl_lru_unit #(
  parameter int NUM_BUFFERS = bbl_pkg::NUM_BUFFERS_DEF,
  localparam int IW         = $clog2(NUM_BUFFERS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bbl_pkg::lru_ctl_t ctl,
  input  logic [IW-1:0]     mtf_idx,
  output bbl_pkg::lru_sts_t sts,
  output logic [IW-1:0]     victim
);
  import bbl_pkg::*;

  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_BUFFERS - 1);

  walk_state_t             wstate_r, wstate_nxt;
  logic [IW-1:0]           pos_r, pos_nxt;
  logic [IW-1:0]           prev_r, prev_nxt;
  logic [IW-1:0]           tgt_r, tgt_nxt;
  logic [NUM_BUFFERS-1:0]  ovr_r, ovr_nxt;

  logic                    ram_we;
  logic [IW-1:0]           ram_waddr;
  logic [IW-1:0]           ram_wdata;
  logic                    ram_re;
  logic [IW-1:0]           ram_raddr;
  logic [IW-1:0]           ram_rdata;
  logic [IW-1:0]           eff;

  bbl_ram #(
    .DATA_W (IW),
    .DEPTH  (NUM_BUFFERS)
  ) u_order_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // A position never written since reset or empty holds its own index.
  assign eff    = ovr_r[pos_r] ? ram_rdata : pos_r;
  assign victim = eff;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wstate_r <= W_IDLE;
      ovr_r    <= '0;
    end else begin
      wstate_r <= wstate_nxt;
      ovr_r    <= ovr_nxt;
    end
  end

  // Walk datapath registers.
  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    prev_r <= prev_nxt;
    tgt_r  <= tgt_nxt;
  end

  // Next state and RAM controls.
  always_comb begin
    wstate_nxt = wstate_r;
    pos_nxt    = pos_r;
    prev_nxt   = prev_r;
    tgt_nxt    = tgt_r;
    ovr_nxt    = ovr_r;
    ram_we     = 1'b0;
    ram_waddr  = pos_r;
    ram_wdata  = prev_r;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    sts        = '0;
    case (wstate_r)
      W_IDLE: begin
        if (ctl.clear) begin
          ovr_nxt = '0;
        end
        if (ctl.mtf_go) begin
          ram_re     = 1'b1;
          ram_raddr  = '0;
          pos_nxt    = '0;
          prev_nxt   = mtf_idx;
          tgt_nxt    = mtf_idx;
          wstate_nxt = W_MOVE;
        end else if (ctl.vict_go) begin
          ram_re     = 1'b1;
          ram_raddr  = LAST_IDX;
          pos_nxt    = LAST_IDX;
          wstate_nxt = W_VICT;
        end
      end
      W_MOVE: begin
        // Entry at pos_r is on the read port; replace it with the one above.
        ram_we         = 1'b1;
        ovr_nxt[pos_r] = 1'b1;
        if (eff == tgt_r || pos_r == LAST_IDX) begin
          sts.mtf_done = 1'b1;
          wstate_nxt   = W_IDLE;
        end else begin
          prev_nxt  = eff;
          pos_nxt   = pos_r + 1'b1;
          ram_re    = 1'b1;
          ram_raddr = pos_r + 1'b1;
        end
      end
      W_VICT: begin
        sts.vict_valid = 1'b1;
        wstate_nxt     = W_IDLE;
      end
      default: begin
        wstate_nxt = W_IDLE;
      end
    endcase
  end

  // Requests arrive only while the unit is idle.
  `BBL_ASSERT_IMP(a_req_when_idle, ctl.mtf_go || ctl.vict_go, wstate_r == W_IDLE)
  // A victim read answers in the cycle after the request.
  `BBL_ASSERT_NEXT(a_vict_latency, ctl.vict_go && !ctl.mtf_go, sts.vict_valid)
  // A walk starts at the head with the target as the carried entry.
  `BBL_ASSERT_IMP(a_walk_start, $rose(wstate_r == W_MOVE), pos_r == '0 && prev_r == tgt_r)

endmodule

// ----- sv/block_buffer_lru_manager.sv -----
// ----------------------------------------------------------------------------
// Block buffer LRU manager
// Fully associative set of block buffers with tags in a RAM, dirty and
// assigned bits in flops, a recency order unit and a write-back scan.
//
//   Channel  Dir  Beat                                     Accepted when
//   in_ch    in   kind, block_number, read_contents        valid && ready
//   out_ch   out  index, writeback, fill, hit, error, last valid && ready
//
// Commands are handled one at a time; ready is high only in the idle state.
// Get: a tag scan from buffer 0 up to the hit, or over all N tags on a miss;
// a miss then fetches a victim if no buffer is empty and reads the old tag;
// the order walk and the response beat follow. Save and flush scan the N
// tags at one a cycle: one beat per dirty buffer, else a single beat.
// Reset is synchronous; the output register stalls the scan on back-pressure.
// ----------------------------------------------------------------------------
`include "block_buffer_lru_manager_assert.svh"

module block_buffer_lru_manager #(
  parameter int NUM_BUFFERS = bbl_pkg::NUM_BUFFERS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bbl_in_if.sink    in_ch,
  bbl_out_if.source out_ch
);
  import bbl_pkg::*;

  localparam int            IW       = $clog2(NUM_BUFFERS);
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_BUFFERS - 1);

  mgr_state_t             state_r, state_nxt;
  logic [BLOCK_W-1:0]     blk_r, blk_nxt;
  logic                   rd_r, rd_nxt;
  logic                   flush_r, flush_nxt;
  logic [IW-1:0]          scan_r, scan_nxt;
  logic                   free_v_r, free_v_nxt;
  logic [IW-1:0]          free_idx_r, free_idx_nxt;
  logic [IW-1:0]          chosen_r, chosen_nxt;
  logic                   any_r, any_nxt;
  result_t                res_r, res_nxt;
  logic [NUM_BUFFERS-1:0] assigned_r, assigned_nxt;
  logic [NUM_BUFFERS-1:0] dirty_r, dirty_nxt;
  logic                   cur_v_r, cur_v_nxt;
  logic [IW-1:0]          cur_r, cur_nxt;
  logic                   out_valid_r, out_valid_nxt;
  result_t                out_data_r, out_nxt;
  logic                   out_load;
  logic                   out_free;

  logic                   tag_we;
  logic [IW-1:0]          tag_waddr;
  logic [BLOCK_W-1:0]     tag_wdata;
  logic                   tag_re;
  logic [IW-1:0]          tag_raddr;
  logic [BLOCK_W-1:0]     tag_rdata;

  lru_ctl_t               lru_ctl;
  lru_sts_t               lru_sts;
  logic [IW-1:0]          lru_idx;
  logic [IW-1:0]          lru_victim;

  logic                   tag_hit;
  logic                   slot_empty;
  logic [NUM_BUFFERS-1:0] above_mask;

  bbl_ram #(
    .DATA_W (BLOCK_W),
    .DEPTH  (NUM_BUFFERS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .re    (tag_re),
    .raddr (tag_raddr),
    .rdata (tag_rdata)
  );

  bbl_lru_unit #(
    .NUM_BUFFERS (NUM_BUFFERS)
  ) u_lru (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (lru_ctl),
    .mtf_idx (lru_idx),
    .sts     (lru_sts),
    .victim  (lru_victim)
  );

  // Port wiring.
  assign in_ch.ready            = (state_r == S_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.buffer_index    = out_data_r.buffer_index;
  assign out_ch.writeback_valid = out_data_r.writeback_valid;
  assign out_ch.writeback_block = out_data_r.writeback_block;
  assign out_ch.fill_valid      = out_data_r.fill_valid;
  assign out_ch.fill_block      = out_data_r.fill_block;
  assign out_ch.hit             = out_data_r.hit;
  assign out_ch.error           = out_data_r.error;
  assign out_ch.last            = out_data_r.last;

  assign out_free = !out_valid_r || out_ch.ready;

  // Tag on the read port belongs to buffer scan_r during the scans.
  assign tag_hit    = assigned_r[scan_r] && (tag_rdata == blk_r);
  assign slot_empty = !assigned_r[scan_r];
  assign above_mask = ({NUM_BUFFERS{1'b1}} << scan_r) << 1;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      assigned_r  <= '0;
      dirty_r     <= '0;
      cur_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      assigned_r  <= assigned_nxt;
      dirty_r     <= dirty_nxt;
      cur_v_r     <= cur_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    blk_r      <= blk_nxt;
    rd_r       <= rd_nxt;
    flush_r    <= flush_nxt;
    scan_r     <= scan_nxt;
    free_v_r   <= free_v_nxt;
    free_idx_r <= free_idx_nxt;
    chosen_r   <= chosen_nxt;
    any_r      <= any_nxt;
    res_r      <= res_nxt;
    cur_r      <= cur_nxt;
    if (out_load) begin
      out_data_r <= out_nxt;
    end
  end

  // Output register: a new beat may load while the old one is taken.
  assign out_valid_nxt = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  // Next state and datapath control.
  always_comb begin
    state_nxt    = state_r;
    blk_nxt      = blk_r;
    rd_nxt       = rd_r;
    flush_nxt    = flush_r;
    scan_nxt     = scan_r;
    free_v_nxt   = free_v_r;
    free_idx_nxt = free_idx_r;
    chosen_nxt   = chosen_r;
    any_nxt      = any_r;
    res_nxt      = res_r;
    assigned_nxt = assigned_r;
    dirty_nxt    = dirty_r;
    cur_v_nxt    = cur_v_r;
    cur_nxt      = cur_r;
    tag_we       = 1'b0;
    tag_waddr    = chosen_r;
    tag_wdata    = blk_r;
    tag_re       = 1'b0;
    tag_raddr    = '0;
    lru_ctl      = '0;
    lru_idx      = chosen_r;
    out_load     = 1'b0;
    out_nxt      = res_r;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          blk_nxt      = in_ch.block_number;
          rd_nxt       = in_ch.read_contents;
          flush_nxt    = (kind_t'(in_ch.kind) == KIND_FLUSH);
          res_nxt      = '0;
          res_nxt.last = 1'b1;
          scan_nxt     = '0;
          free_v_nxt   = 1'b0;
          any_nxt      = 1'b0;
          state_nxt    = S_RESP;
          case (kind_t'(in_ch.kind))
            KIND_GET: begin
              if (in_ch.block_number != BLOCK_NONE) begin
                tag_re    = 1'b1;
                state_nxt = S_TSCAN;
              end
            end
            KIND_UPDATE: begin
              if (cur_v_r) begin
                dirty_nxt[cur_r] = 1'b1;
              end else begin
                res_nxt.error = 1'b1;
              end
            end
            KIND_SAVE, KIND_FLUSH: begin
              tag_re    = 1'b1;
              state_nxt = S_SAVE;
            end
            KIND_EMPTY: begin
              assigned_nxt  = '0;
              dirty_nxt     = '0;
              cur_v_nxt     = 1'b0;
              lru_ctl.clear = 1'b1;
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_TSCAN: begin
        if (tag_hit) begin
          chosen_nxt           = scan_r;
          res_nxt.buffer_index = INDEX_W'(scan_r);
          res_nxt.hit          = 1'b1;
          cur_v_nxt            = 1'b1;
          cur_nxt              = scan_r;
          lru_ctl.mtf_go       = 1'b1;
          lru_idx              = scan_r;
          state_nxt            = S_MTF;
        end else if (scan_r == LAST_IDX) begin
          // Miss: highest empty buffer, else the tail of the recency order.
          if (free_v_r || slot_empty) begin
            chosen_nxt = slot_empty ? scan_r : free_idx_r;
            tag_re     = 1'b1;
            tag_raddr  = slot_empty ? scan_r : free_idx_r;
            state_nxt  = S_OLDTAG;
          end else begin
            lru_ctl.vict_go = 1'b1;
            state_nxt       = S_VICT;
          end
        end else begin
          if (slot_empty) begin
            free_v_nxt   = 1'b1;
            free_idx_nxt = scan_r;
          end
          scan_nxt  = scan_r + 1'b1;
          tag_re    = 1'b1;
          tag_raddr = scan_r + 1'b1;
        end
      end
      S_VICT: begin
        if (lru_sts.vict_valid) begin
          chosen_nxt = lru_victim;
          tag_re     = 1'b1;
          tag_raddr  = lru_victim;
          state_nxt  = S_OLDTAG;
        end
      end
      S_OLDTAG: begin
        // Old tag of the chosen buffer is on the read port.
        res_nxt.buffer_index = INDEX_W'(chosen_r);
        if (dirty_r[chosen_r]) begin
          res_nxt.writeback_valid = 1'b1;
          res_nxt.writeback_block = tag_rdata;
        end
        if (rd_r) begin
          res_nxt.fill_valid = 1'b1;
          res_nxt.fill_block = blk_r;
        end
        tag_we                 = 1'b1;
        assigned_nxt[chosen_r] = 1'b1;
        dirty_nxt[chosen_r]    = 1'b0;
        cur_v_nxt              = 1'b1;
        cur_nxt                = chosen_r;
        lru_ctl.mtf_go         = 1'b1;
        state_nxt              = S_MTF;
      end
      S_MTF: begin
        if (lru_sts.mtf_done) begin
          state_nxt = S_RESP;
        end
      end
      S_SAVE: begin
        if (dirty_r[scan_r] && !out_free) begin
          // Hold this buffer and keep its tag on the read port.
          tag_re    = 1'b1;
          tag_raddr = scan_r;
        end else begin
          if (dirty_r[scan_r]) begin
            out_load                = 1'b1;
            out_nxt                 = '0;
            out_nxt.buffer_index    = INDEX_W'(scan_r);
            out_nxt.writeback_valid = 1'b1;
            out_nxt.writeback_block = tag_rdata;
            out_nxt.last            = ~|(dirty_r & above_mask);
            dirty_nxt[scan_r]       = 1'b0;
            any_nxt                 = 1'b1;
          end
          if (scan_r == LAST_IDX) begin
            if (flush_r) begin
              assigned_nxt = '0;
              cur_v_nxt    = 1'b0;
            end
            state_nxt = (any_r || dirty_r[scan_r]) ? S_IDLE : S_RESP;
          end else begin
            scan_nxt  = scan_r + 1'b1;
            tag_re    = 1'b1;
            tag_raddr = scan_r + 1'b1;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_load  = 1'b1;
          out_nxt   = res_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // A beat never overwrites one that is still waiting.
  `BBL_ASSERT_IMP(a_out_no_overwrite, out_load, !out_valid_r || out_ch.ready)
  // The current buffer always holds an assigned block.
  `BBL_ASSERT_IMP(a_cur_assigned, cur_v_r, assigned_r[cur_r])
  // Only assigned buffers can be dirty.
  `BBL_ASSERT_IMP(a_dirty_assigned, 1'b1, (dirty_r & ~assigned_r) == '0)
  // Every order update is followed by a wait for its completion.
  `BBL_ASSERT_NEXT(a_mtf_wait, lru_ctl.mtf_go, state_r == S_MTF)

endmodule

// ----- verif/tb_block_buffer_lru_manager.sv -----
// ----------------------------------------------------------------------------
// Block buffer LRU manager: self-checking testbench
// Drives get, update, save, flush and empty commands into the manager and
// checks every result beat against a cycle-free model of the tag store,
// dirty marks, recency order and current buffer. A directed opening covers
// the corner cases; a long random phase follows with idling on both sides.
// ----------------------------------------------------------------------------
module tb_block_buffer_lru_manager;
  import bbl_pkg::*;

  localparam int NB         = NUM_BUFFERS_DEF;
  localparam int KIND_MAX   = (1 << KIND_W) - 1;
  localparam int POOL_SIZE  = 12;
  localparam int RAND_ITEMS = 135;
  localparam int MAX_PRINTS = 40;

  // Scoreboard: mirrors the buffer state and queues the beats each command
  // must produce.
  class buffer_mgr_scoreboard;
    logic [BLOCK_W-1:0] tag_copy   [NB];
    bit                 dirty_copy [NB];
    int unsigned        order_copy [NB];
    int unsigned        cur_copy;
    result_t            pending_beats [$];
    int unsigned        mismatches;
    int unsigned        n_cmds;
    int unsigned        n_hits;
    int unsigned        n_writebacks;
    int unsigned        n_fills;
    int unsigned        n_errors;

    function new();
      clear_state();
      mismatches   = 0;
      n_cmds       = 0;
      n_hits       = 0;
      n_writebacks = 0;
      n_fills      = 0;
      n_errors     = 0;
    endfunction

    // State after reset or an empty command.
    function void clear_state();
      int i;
      for (i = 0; i < NB; i++) begin
        tag_copy[i]   = BLOCK_NONE;
        dirty_copy[i] = 1'b0;
        order_copy[i] = i;
      end
      cur_copy = NB;
    endfunction

    // Move a buffer to the most recent position of the order.
    function void promote(int unsigned buf_id);
      int pos;
      int i;
      pos = -1;
      for (i = 0; i < NB; i++) begin
        if (order_copy[i] == buf_id && pos < 0) pos = i;
      end
      if (pos < 0) return;
      for (i = pos; i > 0; i--) order_copy[i] = order_copy[i-1];
      order_copy[0] = buf_id;
    endfunction

    // Work out the beats for one accepted command and update the mirror.
    function void note_command(logic [KIND_W-1:0] k, logic [BLOCK_W-1:0] blk,
                               logic rd);
      result_t     beat;
      int          i;
      int          hit_at;
      int          free_at;
      int unsigned pick;
      int          total;
      int          n;
      beat      = '0;
      beat.last = 1'b1;
      n_cmds++;
      case (k)
        KIND_GET: begin
          // The reserved block number leaves everything untouched.
          if (blk != BLOCK_NONE) begin
            hit_at  = -1;
            free_at = -1;
            for (i = 0; i < NB && hit_at < 0; i++) begin
              if (tag_copy[i] == blk) hit_at = i;
              else if (tag_copy[i] == BLOCK_NONE) free_at = i;
            end
            if (hit_at >= 0) begin
              pick     = hit_at;
              beat.hit = 1'b1;
              n_hits++;
            end else begin
              // Highest free buffer, else the least recently used one.
              pick = (free_at >= 0) ? free_at : order_copy[NB-1];
              if (dirty_copy[pick]) begin
                beat.writeback_valid = 1'b1;
                beat.writeback_block = tag_copy[pick];
                dirty_copy[pick]     = 1'b0;
                n_writebacks++;
              end
              tag_copy[pick] = blk;
              if (rd) begin
                beat.fill_valid = 1'b1;
                beat.fill_block = blk;
                n_fills++;
              end
            end
            cur_copy = pick;
            promote(pick);
            beat.buffer_index = pick[INDEX_W-1:0];
          end
          pending_beats.push_back(beat);
        end
        KIND_UPDATE: begin
          if (cur_copy < NB) begin
            dirty_copy[cur_copy] = 1'b1;
          end else begin
            beat.error = 1'b1;
            n_errors++;
          end
          pending_beats.push_back(beat);
        end
        KIND_SAVE, KIND_FLUSH: begin
          // One write-back beat per dirty buffer, lowest index first.
          total = 0;
          for (i = 0; i < NB; i++) if (dirty_copy[i]) total++;
          n = 0;
          for (i = 0; i < NB; i++) begin
            if (dirty_copy[i]) begin
              n++;
              beat                 = '0;
              beat.buffer_index    = i[INDEX_W-1:0];
              beat.writeback_valid = 1'b1;
              beat.writeback_block = tag_copy[i];
              beat.last            = (n == total);
              pending_beats.push_back(beat);
              dirty_copy[i] = 1'b0;
              n_writebacks++;
            end
            if (k == KIND_FLUSH) tag_copy[i] = BLOCK_NONE;
          end
          if (k == KIND_FLUSH) cur_copy = NB;
          if (total == 0) begin
            beat      = '0;
            beat.last = 1'b1;
            pending_beats.push_back(beat);
          end
        end
        KIND_EMPTY: begin
          clear_state();
          pending_beats.push_back(beat);
        end
        default: begin
          pending_beats.push_back(beat);
        end
      endcase
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTS) $display("mismatch: %s", msg);
    endtask

    // Compare one result beat with the oldest pending one.
    task check_beat(result_t got);
      result_t want;
      if (pending_beats.size() == 0) begin
        report("result beat arrived with nothing pending");
        return;
      end
      want = pending_beats.pop_front();
      if (got.buffer_index !== want.buffer_index)
        report($sformatf("buffer_index %0d, wanted %0d", got.buffer_index,
                         want.buffer_index));
      if (got.writeback_valid !== want.writeback_valid)
        report($sformatf("writeback_valid %b, wanted %b", got.writeback_valid,
                         want.writeback_valid));
      if (got.writeback_block !== want.writeback_block)
        report($sformatf("writeback_block %h, wanted %h", got.writeback_block,
                         want.writeback_block));
      if (got.fill_valid !== want.fill_valid)
        report($sformatf("fill_valid %b, wanted %b", got.fill_valid,
                         want.fill_valid));
      if (got.fill_block !== want.fill_block)
        report($sformatf("fill_block %h, wanted %h", got.fill_block,
                         want.fill_block));
      if (got.hit !== want.hit)
        report($sformatf("hit %b, wanted %b", got.hit, want.hit));
      if (got.error !== want.error)
        report($sformatf("error %b, wanted %b", got.error, want.error));
      if (got.last !== want.last)
        report($sformatf("last %b, wanted %b", got.last, want.last));
    endtask
  endclass

  logic clk;
  logic rst_n;

  bbl_in_if  in_ch ();
  bbl_out_if out_ch ();

  block_buffer_lru_manager uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  buffer_mgr_scoreboard book;
  bit                   no_idle;
  int unsigned          ready_hold;
  int unsigned          ignored_cmds;
  logic [BLOCK_W-1:0]   block_pool [POOL_SIZE];
  result_t              seen_beat;

  // Clock.
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  // Result side back-pressure.
  always @(posedge clk) begin
    if (no_idle) begin
      ready_hold = 0;
      out_ch.ready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold--;
      out_ch.ready <= 1'b0;
    end else begin
      ready_hold = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      out_ch.ready <= (ready_hold == 0);
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen_beat.buffer_index    = out_ch.buffer_index;
      seen_beat.writeback_valid = out_ch.writeback_valid;
      seen_beat.writeback_block = out_ch.writeback_block;
      seen_beat.fill_valid      = out_ch.fill_valid;
      seen_beat.fill_block      = out_ch.fill_block;
      seen_beat.hit             = out_ch.hit;
      seen_beat.error           = out_ch.error;
      seen_beat.last            = out_ch.last;
      book.check_beat(seen_beat);
    end
  end

  // Send one command beat; valid stays high when the next beat follows
  // without a gap.
  task automatic send_command(input logic [KIND_W-1:0] k,
                              input logic [BLOCK_W-1:0] blk, input logic rd);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.kind          <= k;
    in_ch.block_number  <= blk;
    in_ch.read_contents <= rd;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    book.note_command(k, blk, rd);
    if ((k == KIND_GET && blk == BLOCK_NONE) || k > KIND_EMPTY) ignored_cmds++;
  endtask

  // Hold the command side until every pending beat has arrived.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (book.pending_beats.size() != 0);
  endtask

  // One random command, mostly gets over a small block pool so that hits,
  // evictions and write-backs are frequent.
  task automatic send_random_item(output bit counted);
    int unsigned        r;
    logic [KIND_W-1:0]  k;
    logic [BLOCK_W-1:0] blk;
    logic               rd;
    r   = $urandom_range(0, 99);
    rd  = 1'($urandom_range(0, 1));
    blk = $urandom();
    if ($urandom_range(0, 19) == 0)
      block_pool[$urandom_range(0, POOL_SIZE-1)] = $urandom();
    if (r < 55) begin
      k   = KIND_GET;
      blk = block_pool[$urandom_range(0, POOL_SIZE-1)];
    end else if (r < 75) begin
      k = KIND_UPDATE;
    end else if (r < 82) begin
      k = KIND_SAVE;
    end else if (r < 87) begin
      k = KIND_FLUSH;
    end else if (r < 90) begin
      k = KIND_EMPTY;
    end else if (r < 94) begin
      k = KIND_GET;
    end else if (r < 97) begin
      k   = KIND_GET;
      blk = BLOCK_NONE;
    end else begin
      k = KIND_W'($urandom_range(int'(KIND_EMPTY) + 1, KIND_MAX));
    end
    counted = !((k == KIND_GET && blk == BLOCK_NONE) || k > KIND_EMPTY);
    send_command(k, blk, rd);
  endtask

  // Stimulus.
  initial begin
    int  u;
    int  counted_items;
    int  waited;
    bit  counted;
    book                = new();
    no_idle             = 1'b0;
    ready_hold          = 0;
    ignored_cmds        = 0;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.kind          = KIND_GET;
    in_ch.block_number  = '0;
    in_ch.read_contents = 1'b0;
    out_ch.ready        = 1'b0;
    for (u = 0; u < POOL_SIZE; u++) block_pool[u] = $urandom();
    block_pool[0] = '0;
    block_pool[1] = BLOCK_NONE - 1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Commands on an empty manager: update without a current buffer, save
    // and flush with nothing dirty, the reserved block and unused codes.
    send_command(KIND_UPDATE, '0, 1'b0);
    send_command(KIND_SAVE, '0, 1'b0);
    send_command(KIND_FLUSH, '0, 1'b1);
    send_command(KIND_GET, BLOCK_NONE, 1'b1);
    for (u = int'(KIND_EMPTY) + 1; u <= KIND_MAX; u++)
      send_command(u[KIND_W-1:0], BLOCK_NONE, 1'b1);

    // Fill every buffer, two of them dirty, then a hit and two evictions,
    // the first of which must write back a dirty victim.
    send_command(KIND_GET, 32'h0000_0000, 1'b1);
    send_command(KIND_UPDATE, '0, 1'b0);
    send_command(KIND_GET, BLOCK_NONE - 1, 1'b0);
    send_command(KIND_UPDATE, '0, 1'b0);
    send_command(KIND_GET, 32'h8000_0000, 1'b1);
    send_command(KIND_GET, 32'h5555_5555, 1'b0);
    send_command(KIND_GET, 32'hAAAA_AAAA, 1'b1);
    send_command(KIND_GET, 32'h0000_0001, 1'b0);
    send_command(KIND_GET, 32'h7FFF_FFFF, 1'b1);
    send_command(KIND_GET, 32'h1234_5678, 1'b1);
    send_command(KIND_GET, 32'h0000_0000, 1'b1);
    send_command(KIND_GET, 32'h0F0F_0F0F, 1'b1);
    send_command(KIND_GET, 32'hF0F0_F0F0, 1'b0);

    // Write-back scans, then update after flush and a full empty.
    send_command(KIND_SAVE, '0, 1'b0);
    send_command(KIND_UPDATE, '0, 1'b0);
    send_command(KIND_FLUSH, '0, 1'b0);
    send_command(KIND_UPDATE, '0, 1'b0);
    send_command(KIND_EMPTY, '0, 1'b0);

    // Random phase with a stretch without idling and a full drain midway.
    counted_items = 0;
    while (counted_items < RAND_ITEMS) begin
      no_idle = (counted_items >= 60 && counted_items < 95);
      if (counted_items == 110 || $urandom_range(0, 49) == 0) wait_drained();
      send_random_item(counted);
      if (counted) counted_items++;
    end
    no_idle = 1'b0;
    in_ch.valid <= 1'b0;

    // Let the last results arrive, then watch for stray beats.
    waited = 0;
    while (book.pending_beats.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (book.pending_beats.size() != 0)
      book.report($sformatf("%0d result beats never arrived",
                            book.pending_beats.size()));

    $display("Ran %0d commands (%0d ignored by design): %0d hits, %0d write-backs,",
             book.n_cmds, ignored_cmds, book.n_hits, book.n_writebacks);
    $display("%0d fills and %0d update errors; %0d mismatches.",
             book.n_fills, book.n_errors, book.mismatches);
    if (book.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("timeout: the run did not complete");
    $display("TB_ERROR");
    $finish;
  end

endmodule
